FILE: hw/rtl/edcr_pkg.sv
// Shared types and constants for the elastic disk collision response unit.
// Holds the beat structs, status codes, divider widths and lane indexes.
// No dependencies.
package edcr_pkg;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
    logic [15:0]        bounce_a;
    logic [15:0]        bounce_b;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
    logic [1:0]         status;
  } out_t;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_COINCIDENT = 2'd1;
  localparam logic [1:0] ST_ZERO_MASS  = 2'd2;

  // Restoring divider: quotient bits equal pipeline steps.
  localparam int DIV_Q_W   = 34;
  localparam int DIV_DEN_W = 47;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

  typedef logic [DIV_NUM_W-1:0] num_t;
  typedef logic [DIV_DEN_W-1:0] den_t;
  typedef logic [DIV_Q_W-1:0]   quo_t;

  localparam int LANES   = 4;
  localparam int LANE_AX = 0;
  localparam int LANE_AY = 1;
  localparam int LANE_BX = 2;
  localparam int LANE_BY = 3;

  // Per-item data that rides alongside the arithmetic.
  typedef struct packed {
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic [31:0]        mass_a;
    logic [31:0]        mass_b;
    logic [16:0]        esum;
    logic [1:0]         status;
    logic               sgn_x;
    logic               sgn_y;
  } side_t;

endpackage

FILE: hw/rtl/elastic_disk_collision_response_unit.sv
// Elastic collision response for one pair of disks per beat. The unit takes
// one pair every clock cycle unless the output stalls, and passes each
// through 11 front stages (normalization, dot product, numerators), two
// 34-step restoring divider pipelines with 2 mass-weighting stages between
// them, and 3 back stages ending in the output register. The divider
// pipelines, one quotient bit per stage, set the latency. A stalled output
// holds the whole pipeline; the input stall is high exactly while a result
// waits in the output register and out_stall is high.
module elastic_disk_collision_response_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  edcr_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output edcr_pkg::out_t out_data
);

  localparam int STEPS = edcr_pkg::DIV_Q_W;
  localparam int L     = edcr_pkg::LANES;

  logic            en;
  logic            f_valid, m_valid;
  edcr_pkg::num_t  f_num_x, f_num_y;
  edcr_pkg::den_t  f_d2;
  edcr_pkg::side_t f_side, m_side;
  edcr_pkg::quo_t  c_x, c_y;
  edcr_pkg::num_t  m_num [L];
  edcr_pkg::den_t  m_den;
  edcr_pkg::quo_t  t_q [L];

  logic [STEPS-1:0] v1_r, v2_r;
  edcr_pkg::side_t  side1_r [STEPS];
  edcr_pkg::side_t  side2_r [STEPS];

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  edcr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (f_valid),
    .num_x     (f_num_x),
    .num_y     (f_num_y),
    .d2        (f_d2),
    .side      (f_side)
  );

  edcr_div u_div_cx (.clk(clk), .en(en), .num(f_num_x), .den(f_d2), .quo(c_x));
  edcr_div u_div_cy (.clk(clk), .en(en), .num(f_num_y), .den(f_d2), .quo(c_y));

  // Carry valid and item data alongside each divider pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= '0;
      v2_r <= '0;
    end else if (en) begin
      v1_r <= {v1_r[STEPS-2:0], f_valid};
      v2_r <= {v2_r[STEPS-2:0], m_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r[0] <= f_side;
      side2_r[0] <= m_side;
      for (int i = 1; i < STEPS; i++) begin
        side1_r[i] <= side1_r[i-1];
        side2_r[i] <= side2_r[i-1];
      end
    end
  end

  edcr_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v1_r[STEPS-1]),
    .c_x       (c_x),
    .c_y       (c_y),
    .side_in   (side1_r[STEPS-1]),
    .out_valid (m_valid),
    .num       (m_num),
    .den       (m_den),
    .side_out  (m_side)
  );

  for (genvar l = 0; l < L; l++) begin : g_t
    edcr_div u_div_t (.clk(clk), .en(en), .num(m_num[l]), .den(m_den), .quo(t_q[l]));
  end

  edcr_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r[STEPS-1]),
    .q         (t_q),
    .side_in   (side2_r[STEPS-1]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

FILE: hw/rtl/edcr_div.sv
// Pipelined restoring divider lane, one quotient bit per stage.
// Depends on edcr_pkg for the numerator, divisor and quotient widths.
module edcr_div (
  input  logic          clk,
  input  logic          en,
  input  edcr_pkg::num_t num,
  input  edcr_pkg::den_t den,
  output edcr_pkg::quo_t quo
);

  localparam int STEPS = edcr_pkg::DIV_Q_W;
  localparam int W     = edcr_pkg::DIV_DEN_W;

  logic [W-1:0]     rem_r [STEPS];
  logic [W-1:0]     rem_nxt [STEPS];
  logic [W-1:0]     den_r [STEPS];
  logic [W-1:0]     den_nxt [STEPS];
  logic [STEPS-1:0] low_r [STEPS];
  logic [STEPS-1:0] low_nxt [STEPS];
  logic [STEPS-1:0] quo_r [STEPS];
  logic [STEPS-1:0] quo_nxt [STEPS];

  always_comb begin
    logic [W-1:0]     r_in;
    logic [W-1:0]     d_in;
    logic [STEPS-1:0] l_in;
    logic [STEPS-1:0] q_in;
    logic [W:0]       trial;
    for (int s = 0; s < STEPS; s++) begin
      if (s == 0) begin
        r_in = num[edcr_pkg::DIV_NUM_W-1:STEPS];
        l_in = num[STEPS-1:0];
        q_in = '0;
        d_in = den;
      end else begin
        r_in = rem_r[s-1];
        l_in = low_r[s-1];
        q_in = quo_r[s-1];
        d_in = den_r[s-1];
      end
      trial = {r_in, l_in[STEPS-1]};
      if (trial >= {1'b0, d_in}) begin
        rem_nxt[s] = W'(trial - {1'b0, d_in});
        quo_nxt[s] = {q_in[STEPS-2:0], 1'b1};
      end else begin
        rem_nxt[s] = trial[W-1:0];
        quo_nxt[s] = {q_in[STEPS-2:0], 1'b0};
      end
      low_nxt[s] = {l_in[STEPS-2:0], 1'b0};
      den_nxt[s] = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        rem_r[s] <= rem_nxt[s];
        den_r[s] <= den_nxt[s];
        low_r[s] <= low_nxt[s];
        quo_r[s] <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_r[STEPS-1];

endmodule

FILE: hw/rtl/edcr_front.sv
// Front end: centre-line difference, status, direction normalization,
// dot product, squared length and the first divider's numerators.
// Depends on edcr_pkg.
module edcr_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  edcr_pkg::in_t   in_data,
  output logic            out_valid,
  output edcr_pkg::num_t  num_x,
  output edcr_pkg::num_t  num_y,
  output edcr_pkg::den_t  d2,
  output edcr_pkg::side_t side
);

  localparam int        STAGES   = 11;
  localparam logic [4:0] NORM_POS = 5'd22;

  function automatic logic [4:0] lead_pos(input logic [31:0] v);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // Bring the larger magnitude into [2^22, 2^23); right shifts truncate.
  function automatic logic [22:0] norm(input logic [31:0] a, input logic [4:0] p);
    logic [31:0] t;
    if (p >= NORM_POS) t = a >> (p - NORM_POS);
    else               t = a << (NORM_POS - p);
    return t[22:0];
  endfunction

  logic [STAGES-1:0] v_r;

  edcr_pkg::side_t side1_nxt, side9_nxt;
  edcr_pkg::side_t side1_r, side2_r, side3_r, side4_r, side5_r, side6_r, side7_r, side8_r;
  edcr_pkg::side_t side9_r, side10_r, side11_r;

  logic signed [32:0] dx1_r, dy1_r;
  logic signed [32:0] dux1_r, duy1_r, dux2_r, duy2_r, dux3_r, duy3_r;
  logic signed [32:0] dux4_r, duy4_r, dux5_r, duy5_r, dux6_r, duy6_r;
  logic [31:0]        ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r, m3_r;
  logic               sx2_r, sy2_r, sx3_r, sy3_r, sx4_r, sy4_r, sx5_r, sy5_r;
  logic               sx6_r, sy6_r, sx7_r, sy7_r, sx8_r, sy8_r;
  logic [4:0]         p4_r;
  logic [22:0]        nx5_r, ny5_r, nx6_r, ny6_r, nx7_r, ny7_r, nx8_r, ny8_r, nx9_r, ny9_r;
  logic signed [23:0] dxs6_r, dys6_r;
  logic [45:0]        sqx6_r, sqy6_r;
  logic signed [56:0] pdx7_r, pdy7_r, dot8_r;
  logic [46:0]        d2_7_r, d2_8_r, d2_9_r, d2_10_r, d2_11_r;
  logic [55:0]        dmag9_r;
  logic [50:0]        plx10_r, phx10_r, ply10_r, phy10_r;
  edcr_pkg::num_t     numx11_r, numy11_r;

  always_comb begin
    side1_nxt.vel_a_x = in_data.vel_a_x;
    side1_nxt.vel_a_y = in_data.vel_a_y;
    side1_nxt.vel_b_x = in_data.vel_b_x;
    side1_nxt.vel_b_y = in_data.vel_b_y;
    side1_nxt.mass_a  = in_data.mass_a;
    side1_nxt.mass_b  = in_data.mass_b;
    side1_nxt.esum    = {1'b0, in_data.bounce_a} + {1'b0, in_data.bounce_b};
    side1_nxt.sgn_x   = 1'b0;
    side1_nxt.sgn_y   = 1'b0;
    // Coincident centres take priority over a zero mass sum.
    if (in_data.pos_a_x == in_data.pos_b_x && in_data.pos_a_y == in_data.pos_b_y) begin
      side1_nxt.status = edcr_pkg::ST_COINCIDENT;
    end else if (in_data.mass_a == '0 && in_data.mass_b == '0) begin
      side1_nxt.status = edcr_pkg::ST_ZERO_MASS;
    end else begin
      side1_nxt.status = edcr_pkg::ST_OK;
    end
  end

  // Projection signs: dot sign times direction sign.
  always_comb begin
    side9_nxt       = side8_r;
    side9_nxt.sgn_x = dot8_r[56] ^ sx8_r;
    side9_nxt.sgn_y = dot8_r[56] ^ sy8_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: differences
      dx1_r   <= {in_data.pos_b_x[31], in_data.pos_b_x} - {in_data.pos_a_x[31], in_data.pos_a_x};
      dy1_r   <= {in_data.pos_b_y[31], in_data.pos_b_y} - {in_data.pos_a_y[31], in_data.pos_a_y};
      dux1_r  <= {in_data.vel_b_x[31], in_data.vel_b_x} - {in_data.vel_a_x[31], in_data.vel_a_x};
      duy1_r  <= {in_data.vel_b_y[31], in_data.vel_b_y} - {in_data.vel_a_y[31], in_data.vel_a_y};
      side1_r <= side1_nxt;
      // Stage 2: magnitudes
      ax2_r   <= dx1_r[32] ? 32'(-dx1_r) : dx1_r[31:0];
      ay2_r   <= dy1_r[32] ? 32'(-dy1_r) : dy1_r[31:0];
      sx2_r   <= dx1_r[32];
      sy2_r   <= dy1_r[32];
      dux2_r  <= dux1_r;
      duy2_r  <= duy1_r;
      side2_r <= side1_r;
      // Stage 3: larger magnitude
      m3_r    <= (ax2_r > ay2_r) ? ax2_r : ay2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      sx3_r   <= sx2_r;
      sy3_r   <= sy2_r;
      dux3_r  <= dux2_r;
      duy3_r  <= duy2_r;
      side3_r <= side2_r;
      // Stage 4: leading one
      p4_r    <= lead_pos(m3_r);
      ax4_r   <= ax3_r;
      ay4_r   <= ay3_r;
      sx4_r   <= sx3_r;
      sy4_r   <= sy3_r;
      dux4_r  <= dux3_r;
      duy4_r  <= duy3_r;
      side4_r <= side3_r;
      // Stage 5: normalize
      nx5_r   <= norm(ax4_r, p4_r);
      ny5_r   <= norm(ay4_r, p4_r);
      sx5_r   <= sx4_r;
      sy5_r   <= sy4_r;
      dux5_r  <= dux4_r;
      duy5_r  <= duy4_r;
      side5_r <= side4_r;
      // Stage 6: signed direction and squares
      dxs6_r  <= sx5_r ? -$signed({1'b0, nx5_r}) : $signed({1'b0, nx5_r});
      dys6_r  <= sy5_r ? -$signed({1'b0, ny5_r}) : $signed({1'b0, ny5_r});
      sqx6_r  <= nx5_r * nx5_r;
      sqy6_r  <= ny5_r * ny5_r;
      nx6_r   <= nx5_r;
      ny6_r   <= ny5_r;
      sx6_r   <= sx5_r;
      sy6_r   <= sy5_r;
      dux6_r  <= dux5_r;
      duy6_r  <= duy5_r;
      side6_r <= side5_r;
      // Stage 7: dot terms and squared length
      pdx7_r  <= dux6_r * dxs6_r;
      pdy7_r  <= duy6_r * dys6_r;
      d2_7_r  <= {1'b0, sqx6_r} + {1'b0, sqy6_r};
      nx7_r   <= nx6_r;
      ny7_r   <= ny6_r;
      sx7_r   <= sx6_r;
      sy7_r   <= sy6_r;
      side7_r <= side6_r;
      // Stage 8: dot product
      dot8_r  <= pdx7_r + pdy7_r;
      d2_8_r  <= d2_7_r;
      nx8_r   <= nx7_r;
      ny8_r   <= ny7_r;
      sx8_r   <= sx7_r;
      sy8_r   <= sy7_r;
      side8_r <= side7_r;
      // Stage 9: dot magnitude and projection signs
      dmag9_r <= dot8_r[56] ? 56'(-dot8_r) : dot8_r[55:0];
      d2_9_r  <= d2_8_r;
      nx9_r   <= nx8_r;
      ny9_r   <= ny8_r;
      side9_r <= side9_nxt;
      // Stage 10: partial products of |dot| * |d|
      plx10_r  <= dmag9_r[27:0] * nx9_r;
      phx10_r  <= dmag9_r[55:28] * nx9_r;
      ply10_r  <= dmag9_r[27:0] * ny9_r;
      phy10_r  <= dmag9_r[55:28] * ny9_r;
      d2_10_r  <= d2_9_r;
      side10_r <= side9_r;
      // Stage 11: combine partial products
      numx11_r <= edcr_pkg::num_t'(plx10_r) + (edcr_pkg::num_t'(phx10_r) << 28);
      numy11_r <= edcr_pkg::num_t'(ply10_r) + (edcr_pkg::num_t'(phy10_r) << 28);
      d2_11_r  <= d2_10_r;
      side11_r <= side10_r;
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign num_x     = numx11_r;
  assign num_y     = numy11_r;
  assign d2        = d2_11_r;
  assign side      = side11_r;

endmodule

FILE: hw/rtl/edcr_mix.sv
// Mass weighting: projections times twice the opposite mass, split into
// two partial products, and the mass sum as the second divisor.
// Depends on edcr_pkg.
module edcr_mix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  edcr_pkg::quo_t  c_x,
  input  edcr_pkg::quo_t  c_y,
  input  edcr_pkg::side_t side_in,
  output logic            out_valid,
  output edcr_pkg::num_t  num [edcr_pkg::LANES],
  output edcr_pkg::den_t  den,
  output edcr_pkg::side_t side_out
);

  localparam int L = edcr_pkg::LANES;

  logic [1:0]      v_r;
  logic [49:0]     plo_nxt [L];
  logic [48:0]     phi_nxt [L];
  logic [49:0]     plo1_r [L];
  logic [48:0]     phi1_r [L];
  logic [32:0]     msum1_r;
  edcr_pkg::side_t side1_r, side2_r;
  edcr_pkg::num_t  num2_r [L];
  edcr_pkg::den_t  den2_r;

  always_comb begin
    logic [32:0] cm;
    logic [32:0] mm;
    for (int l = 0; l < L; l++) begin
      cm = (l == edcr_pkg::LANE_AX || l == edcr_pkg::LANE_BX) ? c_x[32:0] : c_y[32:0];
      // Body A takes 2 mB, body B takes 2 mA.
      mm = (l == edcr_pkg::LANE_AX || l == edcr_pkg::LANE_AY) ?
           {side_in.mass_b, 1'b0} : {side_in.mass_a, 1'b0};
      plo_nxt[l] = cm[16:0] * mm;
      phi_nxt[l] = cm[32:17] * mm;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        plo1_r[l] <= plo_nxt[l];
        phi1_r[l] <= phi_nxt[l];
        num2_r[l] <= edcr_pkg::num_t'(plo1_r[l]) + (edcr_pkg::num_t'(phi1_r[l]) << 17);
      end
      msum1_r <= {1'b0, side_in.mass_a} + {1'b0, side_in.mass_b};
      side1_r <= side_in;
      den2_r  <= edcr_pkg::den_t'(msum1_r);
      side2_r <= side1_r;
    end
  end

  assign out_valid = v_r[1];
  assign num       = num2_r;
  assign den       = den2_r;
  assign side_out  = side2_r;

endmodule

FILE: hw/rtl/edcr_out.sv
// Back end: rebuild velocities, scale by summed elasticity, saturate,
// select the status path, and hold the output register.
// Depends on edcr_pkg.
module edcr_out (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  edcr_pkg::quo_t  q [edcr_pkg::LANES],
  input  edcr_pkg::side_t side_in,
  output logic            out_valid,
  output edcr_pkg::out_t  out_data
);

  localparam int                 L      = edcr_pkg::LANES;
  localparam logic signed [53:0] LIM_HI = 54'sd2147483647;
  localparam logic signed [53:0] LIM_LO = -54'sd2147483648;
  localparam logic signed [53:0] RND    = 54'sd65535;

  logic               v1_r, v2_r, out_valid_r;
  logic signed [31:0] u [L];
  logic               sub [L];
  logic signed [35:0] s_nxt [L];
  logic signed [35:0] s1_r [L];
  logic signed [53:0] prod2_r [L];
  logic signed [31:0] sat [L];
  edcr_pkg::side_t    side1_r, side2_r;
  edcr_pkg::out_t     res_nxt, out_data_r;

  always_comb begin
    u[edcr_pkg::LANE_AX] = side_in.vel_a_x;
    u[edcr_pkg::LANE_AY] = side_in.vel_a_y;
    u[edcr_pkg::LANE_BX] = side_in.vel_b_x;
    u[edcr_pkg::LANE_BY] = side_in.vel_b_y;
    // A adds the signed term, B subtracts it.
    sub[edcr_pkg::LANE_AX] = side_in.sgn_x;
    sub[edcr_pkg::LANE_AY] = side_in.sgn_y;
    sub[edcr_pkg::LANE_BX] = !side_in.sgn_x;
    sub[edcr_pkg::LANE_BY] = !side_in.sgn_y;
    for (int l = 0; l < L; l++) begin
      if (sub[l]) s_nxt[l] = 36'(u[l]) - $signed({2'b00, q[l]});
      else        s_nxt[l] = 36'(u[l]) + $signed({2'b00, q[l]});
    end
  end

  always_comb begin
    logic signed [53:0] sc;
    for (int l = 0; l < L; l++) begin
      // Truncate toward zero.
      sc = (prod2_r[l] < 0) ? ((prod2_r[l] + RND) >>> 16) : (prod2_r[l] >>> 16);
      if (sc > LIM_HI)      sat[l] = LIM_HI[31:0];
      else if (sc < LIM_LO) sat[l] = LIM_LO[31:0];
      else                  sat[l] = sc[31:0];
    end
    if (side2_r.status == edcr_pkg::ST_OK) begin
      res_nxt.new_vel_a_x = sat[edcr_pkg::LANE_AX];
      res_nxt.new_vel_a_y = sat[edcr_pkg::LANE_AY];
      res_nxt.new_vel_b_x = sat[edcr_pkg::LANE_BX];
      res_nxt.new_vel_b_y = sat[edcr_pkg::LANE_BY];
    end else begin
      res_nxt.new_vel_a_x = side2_r.vel_a_x;
      res_nxt.new_vel_a_y = side2_r.vel_a_y;
      res_nxt.new_vel_b_x = side2_r.vel_b_x;
      res_nxt.new_vel_b_y = side2_r.vel_b_y;
    end
    res_nxt.status = side2_r.status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        s1_r[l]    <= s_nxt[l];
        prod2_r[l] <= s1_r[l] * $signed({1'b0, side1_r.esum});
      end
      side1_r    <= side_in;
      side2_r    <= side1_r;
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sim/edcr_checker.sv
// Checker for the elastic disk collision response unit: predicts each result from
// the accepted input beats and compares it field by field with the output beats.
// Depends on edcr_pkg.
module edcr_checker
  import edcr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  out_t expected_vels[$];

  // trunc(a * b / den) with the magnitude clamped to 2^62
  function automatic longint scaled_quot(longint a, longint b, longint unsigned den);
    logic [127:0] x;
    logic [127:0] y;
    logic [127:0] q;
    logic         neg;
    if (den == 0) return 0;
    neg = (a < 0) != (b < 0);
    x = 128'(a < 0 ? -a : a);
    y = 128'(b < 0 ? -b : b);
    q = (x * y) / 128'(den);
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic logic [31:0] bounce_sat(longint s, longint esum);
    longint v;
    v = (s * esum) / 65536;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic out_t collide(in_t p);
    longint          uax, uay, ubx, uby, esum, dx, dy, m, dot, cx, cy;
    longint unsigned ma, mb, msum, d2;
    int              k;
    out_t            r;
    uax = p.vel_a_x;
    uay = p.vel_a_y;
    ubx = p.vel_b_x;
    uby = p.vel_b_y;
    ma = p.mass_a;
    mb = p.mass_b;
    msum = ma + mb;
    esum = longint'(p.bounce_a) + longint'(p.bounce_b);
    dx = longint'(p.pos_b_x) - longint'(p.pos_a_x);
    dy = longint'(p.pos_b_y) - longint'(p.pos_a_y);
    r.new_vel_a_x = p.vel_a_x;
    r.new_vel_a_y = p.vel_a_y;
    r.new_vel_b_x = p.vel_b_x;
    r.new_vel_b_y = p.vel_b_y;
    if (dx == 0 && dy == 0) begin
      r.status = ST_COINCIDENT;
      return r;
    end
    if (msum == 0) begin
      r.status = ST_ZERO_MASS;
      return r;
    end
    // bring the larger component of the centre line into [2^22, 2^23)
    m = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy);
    k = 0;
    if (m >= (64'sd1 << 23)) begin
      while ((m >>> k) >= (64'sd1 << 23)) k++;
      dx = dx / (64'sd1 <<< k);
      dy = dy / (64'sd1 <<< k);
    end else begin
      while ((m <<< k) < (64'sd1 << 22)) k++;
      dx = dx * (64'sd1 <<< k);
      dy = dy * (64'sd1 <<< k);
    end
    dot = (ubx - uax) * dx + (uby - uay) * dy;
    d2 = longint'(dx * dx) + longint'(dy * dy);
    cx = scaled_quot(dot, dx, d2);
    cy = scaled_quot(dot, dy, d2);
    r.new_vel_a_x = bounce_sat(uax + scaled_quot(cx, 2 * longint'(mb), msum), esum);
    r.new_vel_a_y = bounce_sat(uay + scaled_quot(cy, 2 * longint'(mb), msum), esum);
    r.new_vel_b_x = bounce_sat(ubx - scaled_quot(cx, 2 * longint'(ma), msum), esum);
    r.new_vel_b_y = bounce_sat(uby - scaled_quot(cy, 2 * longint'(ma), msum), esum);
    r.status = ST_OK;
    return r;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, field, got, want);
    fails++;
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    out_t want;
    if (rst_n && in_valid && !in_stall) expected_vels = {expected_vels, collide(in_data)};
    if (rst_n && out_valid && !out_stall) begin
      if (expected_vels.size() == 0) begin
        report("unexpected beat", 1, 0);
      end else begin
        want = expected_vels.pop_front();
        if (out_data.new_vel_a_x !== want.new_vel_a_x)
          report("new_vel_a_x", out_data.new_vel_a_x, want.new_vel_a_x);
        if (out_data.new_vel_a_y !== want.new_vel_a_y)
          report("new_vel_a_y", out_data.new_vel_a_y, want.new_vel_a_y);
        if (out_data.new_vel_b_x !== want.new_vel_b_x)
          report("new_vel_b_x", out_data.new_vel_b_x, want.new_vel_b_x);
        if (out_data.new_vel_b_y !== want.new_vel_b_y)
          report("new_vel_b_y", out_data.new_vel_b_y, want.new_vel_b_y);
        if (out_data.status !== want.status)
          report("status", out_data.status, want.status);
      end
    end
    pending = expected_vels.size();
  end
endmodule

FILE: sim/tb_top.sv
// Top of the collision response testbench: clock, reset, stimulus with random
// gaps and output stalls, and the verdict. Depends on edcr_pkg, edcr_checker and the unit.
module tb_top;
  import edcr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;
  int   fails;
  int   pending;
  int   sent_pairs;
  int   taken_results;
  bit   stimulus_done;

  elastic_disk_collision_response_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  edcr_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fails(fails), .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one beat and return at the edge that takes it
  task automatic send_pair(in_t pair);
    int gap;
    gap = (sent_pairs >= 500 && sent_pairs < 650) ? 0 : $urandom_range(0, 4);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pair;
    do @(posedge clk); while (in_stall);
    sent_pairs++;
  endtask

  function automatic logic [31:0] shrunk(logic [31:0] v);
    return $signed(v) >>> $urandom_range(0, 31);
  endfunction

  function automatic in_t random_pair();
    in_t p;
    int  kind;
    p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, 16'($urandom), 16'($urandom)};
    kind = $urandom_range(0, 99);
    if (kind < 60) begin
      // nearby disks at a random place
      p.pos_b_x = p.pos_a_x + shrunk($urandom);
      p.pos_b_y = p.pos_a_y + shrunk($urandom);
      p.vel_a_x = shrunk(p.vel_a_x);
      p.vel_a_y = shrunk(p.vel_a_y);
      p.vel_b_x = shrunk(p.vel_b_x);
      p.vel_b_y = shrunk(p.vel_b_y);
      p.mass_a = p.mass_a >> $urandom_range(0, 31);
      p.mass_b = p.mass_b >> $urandom_range(0, 31);
    end else if (kind < 65) begin
      p.pos_b_x = p.pos_a_x;
      p.pos_b_y = p.pos_a_y;
    end else if (kind < 70) begin
      p.mass_a = '0;
      p.mass_b = '0;
    end else if (kind < 75) begin
      if (kind[0]) p.mass_a = '0;
      else p.mass_b = '0;
    end
    return p;
  endfunction

  function automatic in_t make_pair(int pax, int pay, int pbx, int pby, int uax, int uay,
                                    int ubx, int uby, int unsigned ma, int unsigned mb,
                                    int ea, int eb);
    in_t p;
    p = {pax, pay, pbx, pby, uax, uay, ubx, uby, ma, mb, 16'(ea), 16'(eb)};
    return p;
  endfunction

  localparam int MAXI = 32'h7fffffff;
  localparam int MINI = 32'h80000000;
  localparam int ONE  = 32'h00010000;

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    sent_pairs = 0;
    stimulus_done = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // head-on: equal masses with full elasticity, then unequal masses with less
    send_pair(make_pair(0, 0, ONE, 0, ONE, 0, -ONE, 0, ONE, ONE, 32768, 32768));
    send_pair(make_pair(0, 0, 0, ONE, 0, 3 * ONE, 0, -ONE, 2 * ONE, ONE, 16384, 32768));
    // coincident centres, with and without zero mass
    send_pair(make_pair(ONE, -ONE, ONE, -ONE, 5, 6, 7, 8, ONE, ONE, 100, 200));
    send_pair(make_pair(MINI, MAXI, MINI, MAXI, MAXI, MINI, MINI, MAXI, 0, 0, 0, 0));
    // zero mass sum
    send_pair(make_pair(0, 0, ONE, ONE, MAXI, MINI, 123, -456, 0, 0, 65535, 65535));
    // one massless body
    send_pair(make_pair(0, 0, ONE, 0, ONE, 0, 0, 0, 0, ONE, 32768, 32768));
    send_pair(make_pair(0, 0, ONE, 0, ONE, 0, 0, 0, -1, 0, 32768, 32768));
    // widest centre lines, largest masses
    send_pair(make_pair(MINI, MINI, MAXI, MAXI, MINI, MAXI, MAXI, MINI, -1, -1, 65535, 65535));
    send_pair(make_pair(MAXI, MAXI, MINI, MINI, MAXI, MAXI, MINI, MINI, -1, 1, 65535, 0));
    send_pair(make_pair(MAXI, 0, MINI, 1, MINI, 0, MAXI, 0, 1, -1, 0, 65535));
    // shortest centre lines
    send_pair(make_pair(0, 0, 1, 0, 3 * ONE, ONE, -ONE, 0, ONE, ONE, 32768, 32768));
    send_pair(make_pair(-1, -1, -1, 0, ONE, -7 * ONE, 0, 9 * ONE, 3, 5, 40000, 50000));
    send_pair(make_pair(0, 0, -1, 1, 77, -99, 1234, 4321, 1, 1, 32768, 0));
    // saturate with elasticity near two
    send_pair(make_pair(0, 0, ONE, 0, MAXI, MAXI, MINI, MINI, ONE, ONE, 65535, 65535));
    send_pair(make_pair(0, 0, 0, -ONE, MINI, MINI, MAXI, MAXI, 1, -1, 65535, 65535));
    // zero elasticity, zero velocities
    send_pair(make_pair(ONE, ONE, 3 * ONE, 2 * ONE, ONE, ONE, -ONE, 0, ONE, ONE, 0, 0));
    send_pair(make_pair(5, 9, -5, 3, 0, 0, 0, 0, ONE, ONE, 32768, 32768));
    repeat (1200) send_pair(random_pair());
    in_valid <= 1'b0;
    stimulus_done = 1;
  end

  // result side: random stall per beat, a no-stall stretch and one long hold
  initial begin
    int wait_cycles;
    out_stall = 1'b0;
    taken_results = 0;
    @(posedge rst_n);
    forever begin
      if (taken_results == 200) wait_cycles = 400;
      else if (taken_results >= 700 && taken_results < 850) wait_cycles = 0;
      else wait_cycles = $urandom_range(0, 4);
      repeat (wait_cycles) begin
        out_stall <= 1'b1;
        @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken_results++;
    end
  end

  initial begin
    wait (stimulus_done);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fails == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top failed");
    $finish;
  end
endmodule

FILE: filelist.f
hw/rtl/edcr_pkg.sv
hw/rtl/edcr_div.sv
hw/rtl/edcr_front.sv
hw/rtl/edcr_mix.sv
hw/rtl/edcr_out.sv
hw/rtl/elastic_disk_collision_response_unit.sv
sim/edcr_checker.sv
sim/tb_top.sv
